/* hw/rtl/rrt_pkg.sv */
package rrt_pkg;

    // Default storage limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Tile geometry
    localparam int BLOCK_SIZE = 8;
    localparam int PIX_W      = $clog2(BLOCK_SIZE);
    localparam int SAMP_W     = 3;
    localparam int BLK_W      = 2;
    localparam int SAMP_MAX   = 4;

    // Field widths
    localparam int COLOR_W    = 8;
    localparam int MCU_IDX_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int CLAMP_W    = 14;
    localparam int PROD_W     = 24;
    localparam int SUM_W      = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 4'd0,
        REG_IMAGE_HEIGHT    = 4'd1,
        REG_SAMP_HORIZONTAL = 4'd2,
        REG_SAMP_VERTICAL   = 4'd3
    } cfg_reg_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FILL  = 1'b1;

    // Fixed-point colour transform, scale 2^16
    localparam logic [15:0] COEF_Y_R  = 16'd19595;
    localparam logic [15:0] COEF_Y_G  = 16'd38469;
    localparam logic [15:0] COEF_Y_B  = 16'd7471;
    localparam logic [15:0] COEF_CB_R = 16'd11055;
    localparam logic [15:0] COEF_CB_G = 16'd21712;
    localparam logic [15:0] COEF_HALF = 16'd32768;
    localparam logic [15:0] COEF_CR_G = 16'd27439;
    localparam logic [15:0] COEF_CR_B = 16'd5328;
    localparam logic [PROD_W-1:0] CHROMA_OFFSET = 24'd8388608;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [COLOR_W-1:0] y;
        logic [COLOR_W-1:0] cb;
        logic [COLOR_W-1:0] cr;
    } ycc_t;

    typedef struct packed {
        logic capture;
        logic convert;
        logic load_color;
        logic emit;
        logic emit_err;
        logic sweep;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_fill;
        logic want_fill;
        logic fin;
        logic slot_free;
    } dp_status_t;

    function automatic logic [BLK_W-1:0] clamp_samp(input logic [SAMP_W-1:0] v);
        logic [SAMP_W-1:0] dec;
        dec = v - 1'b1;
        if (v == '0)
            return '0;
        else if (v > SAMP_W'(SAMP_MAX))
            return BLK_W'(SAMP_MAX - 1);
        else
            return dec[BLK_W-1:0];
    endfunction

endpackage

/* hw/rtl/rrt_cfg_if.sv */
interface rrt_cfg_if;
    import rrt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/rrt_pix_if.sv */
interface rrt_pix_if;
    import rrt_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, cmd, red, green, blue, input ready);
    modport sink   (input valid, cmd, red, green, blue, output ready);
endinterface

/* hw/rtl/rrt_res_if.sv */
interface rrt_res_if;
    import rrt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COLOR_W-1:0]   luma;
    logic [COLOR_W-1:0]   chroma_blue;
    logic [COLOR_W-1:0]   chroma_red;
    logic [MCU_IDX_W-1:0] mcu_index;
    logic [BLK_W-1:0]     block_row;
    logic [BLK_W-1:0]     block_col;
    logic [PIX_W-1:0]     pixel_row;
    logic [PIX_W-1:0]     pixel_col;
    logic                 last;
    logic                 frame_end;
    logic                 order_error;

    modport source (output valid, luma, chroma_blue, chroma_red, mcu_index, block_row,
                    block_col, pixel_row, pixel_col, last, frame_end, order_error,
                    input ready);
    modport sink   (input valid, luma, chroma_blue, chroma_red, mcu_index, block_row,
                    block_col, pixel_row, pixel_col, last, frame_end, order_error,
                    output ready);
endinterface

/* hw/rtl/rrt_ctrl.sv */
module rrt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rrt_pkg::dp_status_t stat,
    output rrt_pkg::ctrl_cmd_t  ctl
);
    import rrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_COLOR,
        S_EMIT,
        S_REJECT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   accept;

    assign accept   = in_valid && ready_reg;
    assign in_ready = ready_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.capture = accept;
                if (accept)
                    state_next = S_CONVERT;
            end
            S_CONVERT:
            begin
                // drop a request of the wrong kind
                if (stat.is_fill != stat.want_fill)
                    state_next = S_REJECT;
                else
                begin
                    ctl.convert = 1'b1;
                    state_next  = S_COLOR;
                end
            end
            S_COLOR:
            begin
                ctl.load_color = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.slot_free)
                begin
                    ctl.emit = 1'b1;
                    if (stat.fin)
                    begin
                        ctl.advance = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                        ctl.sweep = 1'b1;
                end
            end
            S_REJECT:
            begin
                if (stat.slot_free)
                begin
                    ctl.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

/* hw/rtl/rrt_dp.sv */
module rrt_dp #(
    parameter int MAX_WIDTH  = rrt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rrt_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rrt_cfg_if.sink                       cfg,
    input  logic                          kind,
    input  logic [rrt_pkg::COLOR_W-1:0]   red,
    input  logic [rrt_pkg::COLOR_W-1:0]   green,
    input  logic [rrt_pkg::COLOR_W-1:0]   blue,
    rrt_res_if.source                     results,
    input  rrt_pkg::ctrl_cmd_t            ctl,
    output rrt_pkg::dp_status_t           stat
);
    import rrt_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 32);
    localparam int MCOL_W = $clog2((MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE + 1);
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(BLOCK_SIZE - 1);

    // Configuration, held as last valid position after clamping
    logic [COL_W-1:0] w_last_reg;
    logic [ROW_W-1:0] h_last_reg;
    logic [BLK_W-1:0] sh_last_reg;
    logic [BLK_W-1:0] sv_last_reg;
    logic [CLAMP_W-1:0] wv;
    logic [CLAMP_W-1:0] hv;
    logic [COL_W-1:0] w_last_next;
    logic [ROW_W-1:0] h_last_next;
    logic cfg_wr;
    logic cfg_hit;

    // Position counters
    logic [COL_W-1:0]     col_reg;
    logic [PIX_W-1:0]     pcol_reg;
    logic [BLK_W-1:0]     bcol_reg;
    logic [MCOL_W-1:0]    mcol_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [PIX_W-1:0]     prow_reg;
    logic [BLK_W-1:0]     brow_reg;
    logic [MCU_IDX_W-1:0] row_base_reg;

    // Request and colour path
    logic                fill_reg;
    logic [COLOR_W-1:0]  red_reg;
    logic [COLOR_W-1:0]  green_reg;
    logic [COLOR_W-1:0]  blue_reg;
    logic [PROD_W-1:0]   yr_reg, yg_reg, yb_reg;
    logic [PROD_W-1:0]   cbr_reg, cbg_reg, cbb_reg;
    logic [PROD_W-1:0]   crr_reg, crg_reg, crb_reg;
    logic [SUM_W-1:0]    y_sum, cb_sum, cr_sum;
    ycc_t                conv;
    ycc_t                color_reg;
    ycc_t                mem_q_reg;
    ycc_t                row_mem [MAX_WIDTH];
    logic                mem_we;

    // Result register
    logic                 out_valid_reg;
    ycc_t                 out_color_reg;
    logic [MCU_IDX_W-1:0] out_mcu_reg;
    logic [BLK_W-1:0]     out_brow_reg;
    logic [BLK_W-1:0]     out_bcol_reg;
    logic [PIX_W-1:0]     out_prow_reg;
    logic [PIX_W-1:0]     out_pcol_reg;
    logic                 out_last_reg;
    logic                 out_fend_reg;
    logic                 out_err_reg;

    logic at_last_col;
    logic pad_end;
    logic frame_row;
    logic fin;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_comb
    begin
        unique case (cfg.index)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
            REG_SAMP_HORIZONTAL, REG_SAMP_VERTICAL: cfg_hit = 1'b1;
            default:                                cfg_hit = 1'b0;
        endcase
    end

    assign wv = CLAMP_W'(cfg.data);
    assign hv = CLAMP_W'(cfg.data);
    assign w_last_next = (wv == '0) ? '0 :
                         (wv > CLAMP_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1) :
                         COL_W'(wv - 1'b1);
    assign h_last_next = (hv == '0) ? '0 :
                         (hv > CLAMP_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT - 1) :
                         ROW_W'(hv - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg  <= '0;
            h_last_reg  <= '0;
            sh_last_reg <= '0;
            sv_last_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:     w_last_reg  <= w_last_next;
                REG_IMAGE_HEIGHT:    h_last_reg  <= h_last_next;
                REG_SAMP_HORIZONTAL: sh_last_reg <= clamp_samp(cfg.data[SAMP_W-1:0]);
                REG_SAMP_VERTICAL:   sv_last_reg <= clamp_samp(cfg.data[SAMP_W-1:0]);
                default:             ;
            endcase
        end
    end

    // Position flags
    assign at_last_col = (col_reg == w_last_reg);
    assign pad_end     = (pcol_reg == PIX_LAST) && (bcol_reg == sh_last_reg);
    assign frame_row   = (row_reg >= h_last_reg) && (prow_reg == PIX_LAST) &&
                         (brow_reg == sv_last_reg);
    assign fin         = !at_last_col || pad_end;

    assign stat.is_fill   = fill_reg;
    assign stat.want_fill = (row_reg > h_last_reg);
    assign stat.fin       = fin;
    assign stat.slot_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            pcol_reg     <= '0;
            bcol_reg     <= '0;
            mcol_reg     <= '0;
            row_reg      <= '0;
            prow_reg     <= '0;
            brow_reg     <= '0;
            row_base_reg <= '0;
        end
        else if (cfg_wr && cfg_hit)
        begin
            col_reg      <= '0;
            pcol_reg     <= '0;
            bcol_reg     <= '0;
            mcol_reg     <= '0;
            row_reg      <= '0;
            prow_reg     <= '0;
            brow_reg     <= '0;
            row_base_reg <= '0;
        end
        else if (ctl.advance && at_last_col)
        begin
            col_reg  <= '0;
            pcol_reg <= '0;
            bcol_reg <= '0;
            mcol_reg <= '0;
            if (frame_row)
            begin
                row_reg      <= '0;
                prow_reg     <= '0;
                brow_reg     <= '0;
                row_base_reg <= '0;
            end
            else
            begin
                row_reg  <= row_reg + 1'b1;
                prow_reg <= prow_reg + 1'b1;
                if (prow_reg == PIX_LAST)
                begin
                    if (brow_reg == sv_last_reg)
                    begin
                        brow_reg     <= '0;
                        row_base_reg <= row_base_reg + MCU_IDX_W'(mcol_reg) + 1'b1;
                    end
                    else
                        brow_reg <= brow_reg + 1'b1;
                end
            end
        end
        else if (ctl.advance || ctl.sweep)
        begin
            if (ctl.advance)
                col_reg <= col_reg + 1'b1;
            pcol_reg <= pcol_reg + 1'b1;
            if (pcol_reg == PIX_LAST)
            begin
                if (bcol_reg == sh_last_reg)
                begin
                    bcol_reg <= '0;
                    mcol_reg <= mcol_reg + 1'b1;
                end
                else
                    bcol_reg <= bcol_reg + 1'b1;
            end
        end
    end

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 1'b0;
        else if (ctl.capture)
            fill_reg <= (kind == CMD_FILL);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    // Products, one register stage before the sums
    always_ff @(posedge clk)
    begin
        if (ctl.convert)
        begin
            yr_reg  <= PROD_W'(COEF_Y_R)  * PROD_W'(red_reg);
            yg_reg  <= PROD_W'(COEF_Y_G)  * PROD_W'(green_reg);
            yb_reg  <= PROD_W'(COEF_Y_B)  * PROD_W'(blue_reg);
            cbr_reg <= PROD_W'(COEF_CB_R) * PROD_W'(red_reg);
            cbg_reg <= PROD_W'(COEF_CB_G) * PROD_W'(green_reg);
            cbb_reg <= PROD_W'(COEF_HALF) * PROD_W'(blue_reg);
            crr_reg <= PROD_W'(COEF_HALF) * PROD_W'(red_reg);
            crg_reg <= PROD_W'(COEF_CR_G) * PROD_W'(green_reg);
            crb_reg <= PROD_W'(COEF_CR_B) * PROD_W'(blue_reg);
        end
    end

    assign y_sum  = SUM_W'(yr_reg) + SUM_W'(yg_reg) + SUM_W'(yb_reg);
    assign cb_sum = SUM_W'(cbb_reg) + SUM_W'(CHROMA_OFFSET) - SUM_W'(cbr_reg) - SUM_W'(cbg_reg);
    assign cr_sum = SUM_W'(crr_reg) + SUM_W'(CHROMA_OFFSET) - SUM_W'(crg_reg) - SUM_W'(crb_reg);
    assign conv.y  = y_sum[FRAC_BITS +: COLOR_W];
    assign conv.cb = cb_sum[FRAC_BITS +: COLOR_W];
    assign conv.cr = cr_sum[FRAC_BITS +: COLOR_W];

    // Last image row store
    assign mem_we = ctl.load_color && !fill_reg && (row_reg == h_last_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[col_reg] <= conv;
        if (ctl.convert)
            mem_q_reg <= row_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_color)
            color_reg <= fill_reg ? mem_q_reg : conv;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit || ctl.emit_err)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_color_reg <= color_reg;
            out_mcu_reg   <= row_base_reg + MCU_IDX_W'(mcol_reg);
            out_brow_reg  <= brow_reg;
            out_bcol_reg  <= bcol_reg;
            out_prow_reg  <= prow_reg;
            out_pcol_reg  <= pcol_reg;
            out_last_reg  <= fin;
            out_fend_reg  <= fin && at_last_col && frame_row;
            out_err_reg   <= 1'b0;
        end
        else if (ctl.emit_err)
        begin
            out_color_reg <= '0;
            out_mcu_reg   <= '0;
            out_brow_reg  <= '0;
            out_bcol_reg  <= '0;
            out_prow_reg  <= '0;
            out_pcol_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_fend_reg  <= 1'b0;
            out_err_reg   <= 1'b1;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.luma        = out_color_reg.y;
    assign results.chroma_blue = out_color_reg.cb;
    assign results.chroma_red  = out_color_reg.cr;
    assign results.mcu_index   = out_mcu_reg;
    assign results.block_row   = out_brow_reg;
    assign results.block_col   = out_bcol_reg;
    assign results.pixel_row   = out_prow_reg;
    assign results.pixel_col   = out_pcol_reg;
    assign results.last        = out_last_reg;
    assign results.frame_end   = out_fend_reg;
    assign results.order_error = out_err_reg;

endmodule

/* hw/rtl/rgb_raster_to_ycbcr_mcu_tiler.sv */
// RGB raster to YCbCr MCU tiler.
// Channels: 'pixels' takes one request per accepted valid/ready handshake:
// a pixel (cmd 0, with red/green/blue) or a fill request (cmd 1) for a padding
// row position. 'results' carries YCbCr samples tagged with their place in
// the MCU-tiled image; a request in the last image column gives a burst that
// pads the row out to a whole MCU. 'cfg' writes width, height and sampling
// factors; any write to a known register restarts the frame, and is only to
// be issued while the block is idle.
// Sequence: after acceptance, a request passes the multiply and row-store
// read, the colour load and the output load before its first result sits in
// the output register; padding results follow one per cycle while the receiver
// takes them. The next request is accepted in the cycle after the final result
// of the previous one is loaded, so a request is not taken while one is still
// in flight. A request of the wrong kind gives one result flagged order_error,
// is dropped and leaves the position untouched.
// Reset: geometry returns to 1x1 pixels with 1x1 sampling, positions clear;
// the last-row store holds nothing valid until a last image row is written.
// When the receiver stalls, the output register holds and the block waits.
module rgb_raster_to_ycbcr_mcu_tiler #(
    parameter int MAX_WIDTH  = rrt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rrt_pkg::MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rrt_cfg_if.sink    cfg,
    rrt_pix_if.sink    pixels,
    rrt_res_if.source  results
);
    import rrt_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t stat;

    // Sequencer: accept, convert, colour, emit burst, or reject a wrong-kind request
    rrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Colour transform, position counters, row store and output register
    rrt_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .kind    (pixels.cmd),
        .red     (pixels.red),
        .green   (pixels.green),
        .blue    (pixels.blue),
        .results (results),
        .ctl     (ctl),
        .stat    (stat)
    );

`ifndef SYNTH
    // A dropped request carries no colour or position
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.order_error |->
            results.last && !results.frame_end && results.luma == 8'd0 &&
            results.mcu_index == 16'd0)
        else $error("order error result carries payload");

    // The frame closes on the bottom-right sample of an MCU
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_end |->
            results.last && results.pixel_row == 3'd7 && results.pixel_col == 3'd7)
        else $error("frame end away from MCU corner");

    // One request in flight at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.ready |=> !pixels.ready)
        else $error("request accepted while busy");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rrt_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 11;
    // Generous: several times the slowest run with every sample stalled
    localparam int CYCLE_LIMIT    = 3_000_000;
    // Margin for the block to settle after the last predicted sample
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int RANDOM_ITEMS   = 200;
    localparam int MAX_PRINTED    = 40;
    localparam int STORE_DEPTH    = MAX_WIDTH_DEF;

    // Register index outside the map: the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 4'hF;

    // Fixed-point colour transform, scale 2^16, truncating
    localparam int unsigned FRAC     = 16;
    localparam int unsigned Y_R      = 19595;
    localparam int unsigned Y_G      = 38469;
    localparam int unsigned Y_B      = 7471;
    localparam int unsigned CB_R     = 11055;
    localparam int unsigned CB_G     = 21712;
    localparam int unsigned HALF     = 32768;
    localparam int unsigned CR_G     = 27439;
    localparam int unsigned CR_B     = 5328;
    localparam int unsigned OFFSET_C = 8388608;

    // One sample on the results channel, field for field
    typedef struct packed {
        logic [COLOR_W-1:0]   luma;
        logic [COLOR_W-1:0]   chroma_blue;
        logic [COLOR_W-1:0]   chroma_red;
        logic [MCU_IDX_W-1:0] mcu_index;
        logic [BLK_W-1:0]     block_row;
        logic [BLK_W-1:0]     block_col;
        logic [PIX_W-1:0]     pixel_row;
        logic [PIX_W-1:0]     pixel_col;
        logic                 last;
        logic                 frame_end;
        logic                 order_error;
    } tile_sample_t;

    // Tracks geometry, raster position and the stored last row, predicts the
    // tiled samples for every accepted request and checks what comes out.
    class mcu_sample_book;
        tile_sample_t          due[$];
        ycc_t                  last_row[STORE_DEPTH];
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        logic [SAMP_W-1:0]     samp_h_reg;
        logic [SAMP_W-1:0]     samp_v_reg;
        int unsigned           col_pos;
        int unsigned           row_pos;
        int unsigned           mismatches;
        int unsigned           checked;

        function new();
            width_reg  = 1;
            height_reg = 1;
            samp_h_reg = 1;
            samp_v_reg = 1;
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            checked    = 0;
            foreach (last_row[i])
                last_row[i] = '0;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function int unsigned clamp_to(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        // Effective image and padded sizes from the raw register values
        function void shape(output int unsigned w, output int unsigned h,
                            output int unsigned sh, output int unsigned sv,
                            output int unsigned pad_w, output int unsigned pad_h);
            int unsigned mcu_w;
            int unsigned mcu_h;
            w     = clamp_to(width_reg, MAX_WIDTH_DEF);
            h     = clamp_to(height_reg, MAX_HEIGHT_DEF);
            sh    = clamp_to(samp_h_reg, SAMP_MAX);
            sv    = clamp_to(samp_v_reg, SAMP_MAX);
            mcu_w = BLOCK_SIZE * sh;
            mcu_h = BLOCK_SIZE * sv;
            pad_w = (w + mcu_w - 1) / mcu_w * mcu_w;
            pad_h = (h + mcu_h - 1) / mcu_h * mcu_h;
        endfunction

        function ycc_t ycc_of(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                              logic [COLOR_W-1:0] b);
            int unsigned y;
            int unsigned cb;
            int unsigned cr;
            ycc_t c;
            y    = (Y_R * r + Y_G * g + Y_B * b) >> FRAC;
            cb   = (HALF * b + OFFSET_C - CB_R * r - CB_G * g) >> FRAC;
            cr   = (HALF * r + OFFSET_C - CR_G * g - CR_B * b) >> FRAC;
            c.y  = COLOR_W'(y);
            c.cb = COLOR_W'(cb);
            c.cr = COLOR_W'(cr);
            return c;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_IMAGE_WIDTH:     width_reg  = data;
                REG_IMAGE_HEIGHT:    height_reg = data;
                REG_SAMP_HORIZONTAL: samp_h_reg = SAMP_W'(data);
                REG_SAMP_VERTICAL:   samp_v_reg = SAMP_W'(data);
                default:             return;
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void note_request(logic cmd, logic [COLOR_W-1:0] r,
                                   logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
            int unsigned w, h, sh, sv, pad_w, pad_h;
            int unsigned col, row, end_col;
            bit is_fill;
            bit want_fill;
            ycc_t colour;
            tile_sample_t s;
            shape(w, h, sh, sv, pad_w, pad_h);
            is_fill   = (cmd == CMD_FILL);
            col       = col_pos;
            row       = row_pos;
            want_fill = (row >= h);
            if (col >= w || row >= pad_h)
            begin
                col       = 0;
                row       = 0;
                want_fill = 0;
            end
            // Wrong kind: flag it, drop it, keep the position
            if (is_fill != want_fill)
            begin
                s             = '0;
                s.last        = 1'b1;
                s.order_error = 1'b1;
                due.push_back(s);
                return;
            end
            if (is_fill)
                colour = last_row[col];
            else
            begin
                colour = ycc_of(r, g, b);
                if (row == h - 1)
                    last_row[col] = colour;
            end
            // The last image column repeats its colour out to the padded width
            end_col = (col == w - 1) ? pad_w - 1 : col;
            for (int unsigned c = col; c <= end_col; c++)
            begin
                s.luma        = colour.y;
                s.chroma_blue = colour.cb;
                s.chroma_red  = colour.cr;
                s.mcu_index   = MCU_IDX_W'((row / (BLOCK_SIZE * sv)) *
                                (pad_w / (BLOCK_SIZE * sh)) + c / (BLOCK_SIZE * sh));
                s.block_row   = BLK_W'((row / BLOCK_SIZE) % sv);
                s.block_col   = BLK_W'((c / BLOCK_SIZE) % sh);
                s.pixel_row   = PIX_W'(row % BLOCK_SIZE);
                s.pixel_col   = PIX_W'(c % BLOCK_SIZE);
                s.last        = (c == end_col);
                s.frame_end   = (c == pad_w - 1) && (row == pad_h - 1);
                s.order_error = 1'b0;
                due.push_back(s);
            end
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= pad_h)
                    row = 0;
            end
            col_pos = col;
            row_pos = row;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] sample %0d: %s", $time, checked, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0d, want %0d", name, got, want));
        endtask

        task check_sample(tile_sample_t got);
            tile_sample_t want;
            checked++;
            if (due.size() == 0)
            begin
                report("sample arrived with nothing outstanding");
                return;
            end
            want = due.pop_front();
            compare_field("luma", got.luma, want.luma);
            compare_field("chroma_blue", got.chroma_blue, want.chroma_blue);
            compare_field("chroma_red", got.chroma_red, want.chroma_red);
            compare_field("mcu_index", got.mcu_index, want.mcu_index);
            compare_field("block_row", got.block_row, want.block_row);
            compare_field("block_col", got.block_col, want.block_col);
            compare_field("pixel_row", got.pixel_row, want.pixel_row);
            compare_field("pixel_col", got.pixel_col, want.pixel_col);
            compare_field("last", got.last, want.last);
            compare_field("frame_end", got.frame_end, want.frame_end);
            compare_field("order_error", got.order_error, want.order_error);
        endtask
    endclass

    logic clk;
    logic rst_n;

    rrt_cfg_if cfg_ch();
    rrt_pix_if pix_ch();
    rrt_res_if res_ch();

    mcu_sample_book book = new();

    int unsigned samples_seen  = 0;
    int unsigned requests_sent = 0;
    // Set per phase: offer a request on every cycle with no gaps
    bit          sender_steady = 0;

    rgb_raster_to_ycbcr_mcu_tiler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .pixels  (pix_ch),
        .results (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Abort on a hung run
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Sample every handshake at the clock edge, before the edge's updates land.
    // Register writes, requests and samples never share a cycle with a
    // dependency, but keep this order anyway: configure, predict, then check.
    always @(posedge clk)
    begin
        tile_sample_t got;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            book.write_register(cfg_ch.index, cfg_ch.data);
        if (rst_n && pix_ch.valid && pix_ch.ready)
            book.note_request(pix_ch.cmd, pix_ch.red, pix_ch.green, pix_ch.blue);
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.luma        = res_ch.luma;
            got.chroma_blue = res_ch.chroma_blue;
            got.chroma_red  = res_ch.chroma_red;
            got.mcu_index   = res_ch.mcu_index;
            got.block_row   = res_ch.block_row;
            got.block_col   = res_ch.block_col;
            got.pixel_row   = res_ch.pixel_row;
            got.pixel_col   = res_ch.pixel_col;
            got.last        = res_ch.last;
            got.frame_end   = res_ch.frame_end;
            got.order_error = res_ch.order_error;
            samples_seen++;
            book.check_sample(got);
        end
    end

    // Receiver: alternate calm stretches (always ready) with choppy ones of
    // short and occasional longer stalls. Once, well into the run, hold off
    // for a long stretch so the block fills up and stalls its input.
    initial
    begin
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned roll;
        bit          calm;
        bit          held_once;
        res_ch.ready <= 1'b0;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        held_once  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_once && samples_seen >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (calm_left == 0)
                begin
                    calm      = !calm;
                    calm_left = $urandom_range(40, 300);
                end
                else
                    calm_left--;
                if (stall_left != 0)
                begin
                    stall_left--;
                    res_ch.ready <= 1'b0;
                end
                else if (calm)
                    res_ch.ready <= 1'b1;
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        res_ch.ready <= 1'b1;
                    else if (roll < 95)
                    begin
                        stall_left = $urandom_range(0, 2);
                        res_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        stall_left = $urandom_range(8, 20);
                        res_ch.ready <= 1'b0;
                    end
                end
            end
        end
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (sender_steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Bias towards the colour extremes
    function automatic logic [COLOR_W-1:0] pick_channel();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return COLOR_W'($urandom_range(0, 255));
    endfunction

    // Offer one request and hold it until accepted. Leave valid high on exit:
    // the next call lowers it only if it idles first, so valid never gets two
    // updates in one time step.
    task automatic send_request(input logic cmd, input logic [COLOR_W-1:0] r,
                                input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.cmd   <= cmd;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Fill requests carry random colour too: the block must ignore it
    task automatic send_random(input logic cmd);
        send_request(cmd, pick_channel(), pick_channel(), pick_channel());
    endtask

    // Drop valid, wait for every predicted sample, then let the pipeline settle
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned sh, input int unsigned sv);
        write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_register(REG_SAMP_HORIZONTAL, CFG_DATA_W'(sh));
        write_register(REG_SAMP_VERTICAL, CFG_DATA_W'(sv));
    endtask

    // Walk the padded frame in raster order: pixels over the image rows, fill
    // requests over the padding rows. Stop early after 'cap' requests; now and
    // then slip in a request of the wrong kind first.
    task automatic send_frame(input int unsigned cap, input int unsigned noise_pct);
        int unsigned w, h, sh, sv, pad_w, pad_h, sent;
        logic kind;
        logic wrong;
        book.shape(w, h, sh, sv, pad_w, pad_h);
        sent = 0;
        for (int unsigned row = 0; row < pad_h && sent < cap; row++)
        begin
            kind  = (row >= h) ? CMD_FILL : CMD_PIXEL;
            wrong = (row >= h) ? CMD_PIXEL : CMD_FILL;
            for (int unsigned col = 0; col < w && sent < cap; col++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_random(wrong);
                send_random(kind);
                sent++;
            end
        end
    endtask

    initial
    begin
        int unsigned w_raw, h_raw, sh_raw, sv_raw;
        int unsigned w, h, sh, sv, pad_w, pad_h;
        int unsigned area, first_random;

        rst_n = 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.cmd   <= CMD_PIXEL;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset geometry: a single pixel padded out to one 8x8 MCU. Open with
        // a fill request, which is the wrong kind at the start of a frame.
        send_random(CMD_FILL);
        send_request(CMD_PIXEL, '0, '0, '0);
        repeat (7) send_random(CMD_FILL);
        drain();

        // 2x2 image: colour extremes, then padding rows built from the last row
        set_geometry(2, 2, 1, 1);
        send_request(CMD_PIXEL, '1, '1, '1);
        send_request(CMD_PIXEL, '1, '0, '0);
        send_request(CMD_PIXEL, '0, '1, '0);
        send_request(CMD_PIXEL, '0, '0, '1);
        drain();
        // A write outside the register map must leave the position alone
        write_register(CFG_SPARE_INDEX, '1);
        repeat (5) send_random(CMD_FILL);
        // A pixel where padding is due is the wrong kind
        send_random(CMD_PIXEL);
        repeat (7) send_random(CMD_FILL);
        drain();

        // Largest image: walk only the start of the first row
        set_geometry(MAX_WIDTH_DEF, MAX_HEIGHT_DEF, 1, 1);
        send_frame(16, 5);
        drain();

        // Over-range registers clamp to their maxima; zero sampling counts as 1
        set_geometry(4095, 4095, 7, 0);
        send_frame(12, 5);
        drain();

        // Zero size counts as one pixel; sampling 5 and 6 clamp to 4, giving a
        // 32x32 MCU where every request bursts 32 samples. The long receiver
        // hold-off lands here.
        set_geometry(0, 0, 5, 6);
        send_frame(SAMP_MAX * BLOCK_SIZE, 0);
        drain();

        // Random geometries: mostly whole frames, sometimes two in a row to
        // cross the frame wrap, sometimes cut short and restarted by a write
        first_random = requests_sent;
        while (requests_sent - first_random < RANDOM_ITEMS)
        begin
            w_raw  = $urandom_range(1, 7);
            h_raw  = $urandom_range(1, 12);
            sh_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(1, 4);
            sv_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(1, 4);
            set_geometry(w_raw, h_raw, sh_raw, sv_raw);
            book.shape(w, h, sh, sv, pad_w, pad_h);
            area = w * pad_h;
            sender_steady = ($urandom_range(0, 3) == 0);
            if (area > 150 || $urandom_range(0, 5) == 0)
                send_frame($urandom_range(1, (area > 80) ? 80 : area), 4);
            else
                repeat ($urandom_range(1, 2)) send_frame(area, 4);
            drain();
        end

        if (book.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* rgb_raster_to_ycbcr_mcu_tiler.f */
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_cfg_if.sv
hw/rtl/rrt_pix_if.sv
hw/rtl/rrt_res_if.sv
hw/rtl/rrt_ctrl.sv
hw/rtl/rrt_dp.sv
hw/rtl/rgb_raster_to_ycbcr_mcu_tiler.sv
tb/testbench.sv
